@@ rtl/cvfb_pkg.sv @@
// cvfb_pkg: shared types and constants for the CI-V frame builder
// word layouts of the request and frame channels, frame byte codes, register indexes
// depends on nothing
package cvfb_pkg;

    localparam int FREQ_W = 31;
    localparam int MODE_W = 4;

    // request operation codes
    localparam logic OP_FREQ = 1'b0;
    localparam logic OP_MODE = 1'b1;

    // frame byte codes
    localparam logic [7:0] PREAMBLE    = 8'hFE;
    localparam logic [7:0] END_MARK    = 8'hFD;
    localparam logic [7:0] CMD_FREQ    = 8'h00;
    localparam logic [7:0] CMD_MODE    = 8'h01;
    localparam logic [7:0] FILTER_BYTE = 8'h01;

    // mode four goes out as mode three
    localparam logic [MODE_W-1:0] MODE_FOUR  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_THREE = 4'd3;

    // register indexes and reset values
    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_RIG    = 2'd1;
    localparam logic [1:0] REG_DST    = 2'd2;

    localparam logic [7:0] RIG_RESET = 8'h10;
    localparam logic [7:0] DST_RESET = 8'h00;

    // divide by 100: floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for 32-bit x
    localparam logic [FREQ_W-1:0] RECIP_100   = 31'h51EB851F;
    localparam int                RECIP_SHIFT = 37;

    typedef struct packed {
        logic              operation;
        logic [FREQ_W-1:0] frequency;
        logic [MODE_W-1:0] mode;
    } req_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } frame_t;

    typedef struct packed {
        logic [FREQ_W-1:0] quot;
        logic [7:0]        bcd;
    } digit_pair_t;

endpackage

@@ rtl/cvfb_digit_pair.sv @@
// cvfb_digit_pair: splits off the two lowest decimal digits of a binary value
// returns the value divided by 100 and the packed BCD byte of the remainder
// depends on cvfb_pkg
module cvfb_digit_pair
(
    input  logic [cvfb_pkg::FREQ_W-1:0] value,
    output cvfb_pkg::digit_pair_t       pair
);

    localparam int PROD_W = 2 * cvfb_pkg::FREQ_W;

    logic [PROD_W-1:0]          prod;
    logic [cvfb_pkg::FREQ_W-1:0] quot;
    logic [cvfb_pkg::FREQ_W-1:0] rem;
    logic [6:0]                 rem7;
    logic [14:0]                tens_prod;
    logic [3:0]                 tens;
    logic [6:0]                 ones;

    // reciprocal multiply, exact over the whole input range
    assign prod = PROD_W'(value) * PROD_W'(cvfb_pkg::RECIP_100);
    assign quot = cvfb_pkg::FREQ_W'(prod >> cvfb_pkg::RECIP_SHIFT);

    // remainder = value - 100 * quot, always below 100
    assign rem  = value - ((quot << 6) + (quot << 5) + (quot << 2));
    assign rem7 = rem[6:0];

    // tens = rem7 / 10 via * 205 >> 11, exact for values below 1029
    assign tens_prod = 15'(rem7) * 15'(205);
    assign tens      = tens_prod[14:11];
    assign ones      = rem7 - {tens, 3'b000} - {2'b00, tens, 1'b0};

    assign pair.quot = quot;
    assign pair.bcd  = {tens, ones[3:0]};

endmodule

@@ rtl/ci_v_frame_builder.sv @@
// ci_v_frame_builder: one request word in, one CI-V frame out as a burst of byte words
// path: request register, byte sequencer, output register, then the first frame byte is shown
// throughput: one byte per cycle unless stalled; next request is held while a frame goes out
// the frame length is set by the byte sequencer, which emits one frame byte per unstalled cycle
// reset: asynchronous, active low; control regs return to defaults, no frame or request in flight
// depends on cvfb_pkg and cvfb_digit_pair
module ci_v_frame_builder
#(
    parameter int BCD_BYTES = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // request channel
    input  logic                  req_valid,
    output logic                  req_stall,
    input  cvfb_pkg::req_t        req_data,

    // frame byte channel
    output logic                  frame_valid,
    input  logic                  frame_stall,
    output cvfb_pkg::frame_t      frame_data,

    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // longest frame sets the byte index width; mode frames are always 8 bytes
    localparam int FREQ_LEN  = 6 + BCD_BYTES;
    localparam int FRAME_MAX = (FREQ_LEN > 8) ? FREQ_LEN : 8;
    localparam int IDX_W     = $clog2(FRAME_MAX);

    localparam logic [IDX_W-1:0] I_PRE0     = IDX_W'(0);
    localparam logic [IDX_W-1:0] I_PRE1     = IDX_W'(1);
    localparam logic [IDX_W-1:0] I_DST      = IDX_W'(2);
    localparam logic [IDX_W-1:0] I_RIG      = IDX_W'(3);
    localparam logic [IDX_W-1:0] I_CMD      = IDX_W'(4);
    localparam logic [IDX_W-1:0] I_BODY     = IDX_W'(5);
    localparam logic [IDX_W-1:0] I_FILTER   = IDX_W'(6);
    localparam logic [IDX_W-1:0] I_MODE_END = IDX_W'(7);
    localparam logic [IDX_W-1:0] I_FREQ_END = IDX_W'(5 + BCD_BYTES);

    // ------------------------------------------------------------------
    // register file
    // ------------------------------------------------------------------
    logic       enable_reg;
    logic [7:0] rig_reg;
    logic [7:0] dst_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            rig_reg    <= cvfb_pkg::RIG_RESET;
            dst_reg    <= cvfb_pkg::DST_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                cvfb_pkg::REG_ENABLE: enable_reg <= pwdata[0];
                cvfb_pkg::REG_RIG:    rig_reg    <= pwdata[7:0];
                cvfb_pkg::REG_DST:    dst_reg    <= pwdata[7:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            cvfb_pkg::REG_ENABLE: prdata = {31'd0, enable_reg};
            cvfb_pkg::REG_RIG:    prdata = {24'd0, rig_reg};
            cvfb_pkg::REG_DST:    prdata = {24'd0, dst_reg};
            default:              prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // request register: holds the next request while a frame goes out
    // ------------------------------------------------------------------
    logic           in_full_reg;
    logic           in_full_next;
    cvfb_pkg::req_t in_data_reg;
    logic           req_take;
    logic           load;

    // stall only on a full holding register, so the next request waits here
    assign req_stall = in_full_reg;
    assign req_take  = req_valid && !req_stall;

    // a request taken while disabled is dropped and never reaches the sequencer
    always_comb
    begin
        in_full_next = in_full_reg;
        if (load)
        begin
            in_full_next = 1'b0;
        end
        if (req_take && enable_reg)
        begin
            in_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            in_data_reg <= req_data;
        end
    end

    // ------------------------------------------------------------------
    // byte sequencer
    // ------------------------------------------------------------------
    logic                        busy_reg;
    logic                        busy_next;
    logic [IDX_W-1:0]            idx_reg;
    logic [IDX_W-1:0]            idx_next;
    logic                        op_reg;
    logic [7:0]                  mode_byte_reg;
    logic [cvfb_pkg::FREQ_W-1:0] freq_work_reg;
    logic [cvfb_pkg::FREQ_W-1:0] freq_work_next;
    logic [7:0]                  mode_byte_in;

    logic                  advance;
    logic                  is_last;
    logic                  frame_done;
    logic                  in_bcd;
    logic [7:0]            cur_byte;
    cvfb_pkg::digit_pair_t pair;

    cvfb_digit_pair u_digit_pair
    (
        .value (freq_work_reg),
        .pair  (pair)
    );

    // output register can take a word when empty or being drained
    assign advance    = !frame_valid || !frame_stall;
    assign is_last    = op_reg ? (idx_reg == I_MODE_END) : (idx_reg == I_FREQ_END);
    assign frame_done = busy_reg && advance && is_last;
    // next request starts in the same cycle the closing byte goes out
    assign load       = in_full_reg && (!busy_reg || frame_done);
    assign in_bcd     = !op_reg && (idx_reg >= I_BODY) && (idx_reg < I_FREQ_END);

    // mode four is sent as three
    assign mode_byte_in = (in_data_reg.mode == cvfb_pkg::MODE_FOUR) ?
                          {4'd0, cvfb_pkg::MODE_THREE} : {4'd0, in_data_reg.mode};

    // byte for the current index
    always_comb
    begin
        if (idx_reg == I_PRE0 || idx_reg == I_PRE1)
        begin
            cur_byte = cvfb_pkg::PREAMBLE;
        end
        else if (idx_reg == I_DST)
        begin
            cur_byte = dst_reg;
        end
        else if (idx_reg == I_RIG)
        begin
            cur_byte = rig_reg;
        end
        else if (idx_reg == I_CMD)
        begin
            cur_byte = op_reg ? cvfb_pkg::CMD_MODE : cvfb_pkg::CMD_FREQ;
        end
        else if (is_last)
        begin
            cur_byte = cvfb_pkg::END_MARK;
        end
        else if (in_bcd)
        begin
            cur_byte = pair.bcd;
        end
        else if (idx_reg == I_BODY)
        begin
            cur_byte = mode_byte_reg;
        end
        else if (idx_reg == I_FILTER)
        begin
            cur_byte = cvfb_pkg::FILTER_BYTE;
        end
        else
        begin
            cur_byte = cvfb_pkg::END_MARK;
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        freq_work_next = freq_work_reg;
        if (busy_reg && advance)
        begin
            idx_next = idx_reg + IDX_W'(1);
            // each bcd byte strips two digits off the working value
            if (in_bcd)
            begin
                freq_work_next = pair.quot;
            end
            if (is_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (load)
        begin
            busy_next      = 1'b1;
            idx_next       = I_PRE0;
            freq_work_next = in_data_reg.frequency;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= I_PRE0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        freq_work_reg <= freq_work_next;
        if (load)
        begin
            op_reg        <= in_data_reg.operation;
            mode_byte_reg <= mode_byte_in;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic             out_valid_reg;
    cvfb_pkg::frame_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg.tx_byte   <= cur_byte;
            out_data_reg.last_byte <= is_last;
        end
    end

    assign frame_valid = out_valid_reg;
    assign frame_data  = out_data_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // nothing pending while disabled keeps the sequencer quiet
    a_disabled_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (!enable_reg && !busy_reg && !in_full_reg) |=> !busy_reg)
        else $error("sequencer started with no request pending");

    // a frame that ends with nothing queued leaves the sequencer idle
    a_frame_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_done && !in_full_reg) |=> !busy_reg)
        else $error("sequencer ran past the closing byte");

    // the marked byte is always the closing code
    a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && frame_data.last_byte) |-> (frame_data.tx_byte == cvfb_pkg::END_MARK))
        else $error("last byte marked on a byte other than the closing code");

endmodule

@@ verif/tb.sv @@
// tb: self-checking bench for ci_v_frame_builder, request words in, frame byte words checked
// frames are predicted in the bench from the request and the register settings
// depends on cvfb_pkg and the ci_v_frame_builder rtl
module tb;

    localparam int BCD_BYTES      = 5;
    localparam int FREQ_W         = cvfb_pkg::FREQ_W;
    localparam int MODE_W         = cvfb_pkg::MODE_W;
    localparam int DRAIN_CYCLES   = 16;    // well past the request-to-output latency of the block
    localparam int WATCHDOG_LIMIT = 3000;  // quiet cycles before the run is declared hung
    localparam int MAX_SHOWN      = 10;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_BURSTY} stall_style_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // request channel
    logic           req_valid = 1'b0;
    logic           req_stall;
    cvfb_pkg::req_t req_data  = '0;

    // frame byte channel
    logic             frame_valid;
    logic             frame_stall = 1'b0;
    cvfb_pkg::frame_t frame_data;

    // register port
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // bench copy of the registers, mirrors every write
    logic       cfg_enable = 1'b0;
    logic [7:0] cfg_rig    = cvfb_pkg::RIG_RESET;
    logic [7:0] cfg_dst    = cvfb_pkg::DST_RESET;

    // frame bytes predicted and not yet seen on the output, oldest first
    cvfb_pkg::frame_t frame_bytes_due[$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;

    // sender and receiver idling knobs, changed per test
    int           sender_max_gap = 0;
    int           burst_left     = 0;
    stall_style_t stall_style    = STALL_NONE;
    int           stall_hold     = 0;

    ci_v_frame_builder #(.BCD_BYTES(BCD_BYTES)) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_data    (req_data),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_data  (frame_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // frame prediction
    // ------------------------------------------------------------------

    function automatic void expect_byte(input logic [7:0] value, input logic closing);
        cvfb_pkg::frame_t w;
        w.tx_byte   = value;
        w.last_byte = closing;
        frame_bytes_due.push_back(w);
    endfunction

    // builds the whole frame that one request should produce
    function automatic void predict_frame(input cvfb_pkg::req_t req);
        int unsigned rest;
        logic [3:0]  lo;
        logic [3:0]  hi;
        logic [3:0]  mode_sent;
        // disabled: the request is swallowed, nothing comes out
        if (!cfg_enable)
            return;
        expect_byte(cvfb_pkg::PREAMBLE, 1'b0);
        expect_byte(cvfb_pkg::PREAMBLE, 1'b0);
        expect_byte(cfg_dst, 1'b0);
        expect_byte(cfg_rig, 1'b0);
        if (req.operation == cvfb_pkg::OP_FREQ)
        begin
            expect_byte(cvfb_pkg::CMD_FREQ, 1'b0);
            // two decimal digits per byte, least significant pair first,
            // digits beyond the packed count fall off the top
            rest = 32'(req.frequency);
            for (int i = 0; i < BCD_BYTES; i++)
            begin
                lo   = 4'(rest % 10);
                rest = rest / 10;
                hi   = 4'(rest % 10);
                rest = rest / 10;
                expect_byte({hi, lo}, 1'b0);
            end
        end
        else
        begin
            expect_byte(cvfb_pkg::CMD_MODE, 1'b0);
            // mode four is reported as mode three, everything else as is
            mode_sent = (req.mode == cvfb_pkg::MODE_FOUR) ? cvfb_pkg::MODE_THREE : req.mode;
            expect_byte({4'd0, mode_sent}, 1'b0);
            expect_byte(cvfb_pkg::FILTER_BYTE, 1'b0);
        end
        expect_byte(cvfb_pkg::END_MARK, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // output checking
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string what, input cvfb_pkg::frame_t want,
                                 input cvfb_pkg::frame_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
            $display("mismatch, %s: expected byte %02h last %0b, got byte %02h last %0b",
                     what, want.tx_byte, want.last_byte, got.tx_byte, got.last_byte);
    endtask

    // every accepted frame word is matched against the oldest prediction
    always @(posedge clk)
    begin : check_frame
        cvfb_pkg::frame_t want;
        if (rst_n && frame_valid && !frame_stall)
        begin
            if (frame_bytes_due.size() == 0)
            begin
                note_mismatch("word with none due", '0, frame_data);
            end
            else
            begin
                want = frame_bytes_due.pop_front();
                if (frame_data.tx_byte !== want.tx_byte)
                    note_mismatch("tx_byte", want, frame_data);
                else if (frame_data.last_byte !== want.last_byte)
                    note_mismatch("last_byte", want, frame_data);
            end
        end
    end

    // receiver stall pattern: none, sparse random, or alternating runs
    always @(posedge clk)
    begin
        if (stall_hold != 0)
        begin
            stall_hold <= stall_hold - 1;
        end
        else
        begin
            case (stall_style)
                STALL_NONE:
                    frame_stall <= 1'b0;
                STALL_LIGHT:
                    frame_stall <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    frame_stall <= ~frame_stall;
                    stall_hold  <= frame_stall ? int'($urandom_range(0, 5))
                                               : int'($urandom_range(0, 12));
                end
            endcase
        end
    end

    // watchdog: too long without any word moving or register access means a hang
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (frame_valid && !frame_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ci_v_frame_builder verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offers one request word, holds it until accepted, then predicts its frame
    task automatic send_request(input cvfb_pkg::req_t req);
        // sender works in bursts; between bursts valid drops for a random gap
        if (sender_max_gap != 0 && burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, sender_max_gap)) @(posedge clk);
            burst_left = $urandom_range(1, 8);
        end
        req_valid <= 1'b1;
        req_data  <= req;
        do
            @(posedge clk);
        while (req_stall);
        if (burst_left != 0)
            burst_left--;
        predict_frame(req);
    endtask

    // stops sending and waits until every predicted byte has come out
    task automatic wait_frames_drained();
        req_valid <= 1'b0;
        while (frame_bytes_due.size() != 0)
            @(posedge clk);
        // a request swallowed while disabled leaves nothing to wait on, so give
        // the block time to settle anyway
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write: setup cycle, then access cycle until pready
    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            cvfb_pkg::REG_ENABLE: cfg_enable = value[0];
            cvfb_pkg::REG_RIG:    cfg_rig    = value[7:0];
            cvfb_pkg::REG_DST:    cfg_dst    = value[7:0];
            default:              ;
        endcase
    endtask

    task automatic set_registers(input logic en, input logic [7:0] rig, input logic [7:0] dst);
        // upper data bits are junk on purpose, only the low bits should count
        write_register(cvfb_pkg::REG_RIG, ($urandom & 32'hFFFF_FF00) | 32'(rig));
        write_register(cvfb_pkg::REG_DST, ($urandom & 32'hFFFF_FF00) | 32'(dst));
        write_register(cvfb_pkg::REG_ENABLE, ($urandom & 32'hFFFF_FFFE) | 32'(en));
    endtask

    function automatic cvfb_pkg::req_t make_request(input logic op,
                                                    input logic [FREQ_W-1:0] freq,
                                                    input logic [MODE_W-1:0] mode);
        cvfb_pkg::req_t r;
        r.operation = op;
        r.frequency = freq;
        r.mode      = mode;
        return r;
    endfunction

    // random request: full-range values plus small values, decade edges and the top end
    function automatic cvfb_pkg::req_t random_request();
        cvfb_pkg::req_t r;
        int unsigned    decade;
        r.operation = 1'($urandom_range(0, 1));
        r.mode      = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 3))
            0: r.frequency = FREQ_W'($urandom);
            1: r.frequency = FREQ_W'($urandom_range(0, 99999));
            2:
            begin
                decade = 1;
                repeat ($urandom_range(0, 9)) decade = decade * 10;
                r.frequency = FREQ_W'(decade - $urandom_range(0, 1));
            end
            default: r.frequency = FREQ_W'(32'h7FFF_FFFF - $urandom_range(0, 1000));
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // enable is clear out of reset, so requests must vanish
    task automatic test_disabled_after_reset();
        sender_max_gap = 0;
        stall_style    = STALL_NONE;
        send_request(make_request(cvfb_pkg::OP_FREQ, '0, '0));
        send_request(make_request(cvfb_pkg::OP_MODE, 31'd12345, cvfb_pkg::MODE_FOUR));
        send_request(make_request(cvfb_pkg::OP_FREQ, 31'h7FFF_FFFF, 4'd15));
        wait_frames_drained();
    endtask

    // only enable is written: addresses must still be at their reset values
    task automatic test_default_addresses();
        write_register(cvfb_pkg::REG_ENABLE, 32'd1);
        send_request(make_request(cvfb_pkg::OP_FREQ, 31'd1234567890, 4'd0));
        send_request(make_request(cvfb_pkg::OP_MODE, 31'd0, cvfb_pkg::MODE_FOUR));
        wait_frames_drained();
    endtask

    // frequency digit packing at the extremes and at carries
    task automatic test_frequency_extremes();
        set_registers(1'b1, 8'h00, 8'hFF);
        stall_style = STALL_LIGHT;
        send_request(make_request(cvfb_pkg::OP_FREQ, 31'd0, 4'd15));
        send_request(make_request(cvfb_pkg::OP_FREQ, 31'd9, 4'd0));
        send_request(make_request(cvfb_pkg::OP_FREQ, 31'd10, 4'd0));
        send_request(make_request(cvfb_pkg::OP_FREQ, 31'd99, 4'd0));
        send_request(make_request(cvfb_pkg::OP_FREQ, 31'd100, 4'd0));
        send_request(make_request(cvfb_pkg::OP_FREQ, 31'd999999999, 4'd0));
        send_request(make_request(cvfb_pkg::OP_FREQ, 31'd1000000000, 4'd0));
        send_request(make_request(cvfb_pkg::OP_FREQ, 31'h7FFF_FFFF, 4'd0));
        wait_frames_drained();
    endtask

    // mode byte mapping, with mode four as the one remapped value
    task automatic test_mode_codes();
        set_registers(1'b1, 8'hFF, 8'h00);
        stall_style = STALL_BURSTY;
        send_request(make_request(cvfb_pkg::OP_MODE, 31'h7FFF_FFFF, 4'd0));
        send_request(make_request(cvfb_pkg::OP_MODE, 31'd0, 4'd1));
        send_request(make_request(cvfb_pkg::OP_MODE, 31'd0, cvfb_pkg::MODE_THREE));
        send_request(make_request(cvfb_pkg::OP_MODE, 31'd0, cvfb_pkg::MODE_FOUR));
        send_request(make_request(cvfb_pkg::OP_MODE, 31'd0, 4'd5));
        send_request(make_request(cvfb_pkg::OP_MODE, 31'd0, 4'd15));
        wait_frames_drained();
    endtask

    // one phase of random traffic under one register setting and idling style
    task automatic run_random_phase(input logic en, input logic [7:0] rig, input logic [7:0] dst,
                                    input int count, input int max_gap,
                                    input stall_style_t style);
        wait_frames_drained();
        set_registers(en, rig, dst);
        sender_max_gap = max_gap;
        stall_style    = style;
        burst_left     = 0;
        repeat (count) send_request(random_request());
    endtask

    // sender holds off mid-stream until every predicted byte is out, then resumes
    task automatic test_drain_pause();
        run_random_phase(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 20, 3,
                         STALL_LIGHT);
        wait_frames_drained();
        repeat (20) send_request(random_request());
    endtask

    task automatic test_random_traffic();
        // stretch with no idling on either side
        run_random_phase(1'b1, 8'h00, 8'hFF, 40, 0, STALL_NONE);
        run_random_phase(1'b1, 8'hFF, 8'h00, 40, 6, STALL_LIGHT);
        // disabled again: everything here is swallowed
        run_random_phase(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 12, 3,
                         STALL_LIGHT);
        // addresses that look like preamble and end marker
        run_random_phase(1'b1, cvfb_pkg::PREAMBLE, cvfb_pkg::END_MARK, 40, 10, STALL_BURSTY);
        run_random_phase(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 40, 4,
                         STALL_BURSTY);
        run_random_phase(1'b1, cvfb_pkg::RIG_RESET, cvfb_pkg::DST_RESET, 40, 2, STALL_LIGHT);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_disabled_after_reset();
        test_default_addresses();
        test_frequency_extremes();
        test_mode_codes();
        test_drain_pause();
        test_random_traffic();

        // wait for the tail of the last frame, then settle
        wait_frames_drained();
        if (mismatch_count == 0 && frame_bytes_due.size() == 0)
            $display("ci_v_frame_builder verification clean");
        else
            $display("ci_v_frame_builder verification failed");
        $finish;
    end

endmodule
